// File: rtl/core/srev_pkg.sv
// Shared types and constants for the stream group reverser.
`timescale 1ns / 1ps
package srev_pkg;

   // Default and upper bound of the group buffer depth
   localparam int MAX_GROUP_DEFAULT = 16;
   localparam int MAX_GROUP_LIMIT   = 256;

   // Descriptor element count width, covers MAX_GROUP_LIMIT
   localparam int DESC_CNT_W = $clog2(MAX_GROUP_LIMIT + 1);

   // Configuration register
   localparam int         GS_W     = 5;
   localparam logic [4:0] GS_RESET = 5'd1;
   // Register index as decoded from paddr[2]
   localparam logic       REG_GROUP_SIZE = 1'b0;

   // One finished group handed from front to back
   typedef struct packed {
      logic                  bank;
      logic [DESC_CNT_W-1:0] count;
      logic                  last;
   } desc_type;

   // Back tells front that a bank has been fully read
   typedef struct packed {
      logic valid;
      logic bank;
   } rel_type;

   // One result item
   typedef struct packed {
      logic signed [31:0] out_value;
      logic               list_done;
      logic               run_last;
   } rsp_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

endpackage

// File: rtl/core/srev_bank_mem.sv
// Two-bank group buffer: one write port, one registered read port.
`timescale 1ns / 1ps
module srev_bank_mem import srev_pkg::*; #(
   parameter int MAX_GROUP = MAX_GROUP_DEFAULT,
   localparam int AW = $clog2(2 * MAX_GROUP)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic signed [31:0] wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic signed [31:0] rd_data
);

   logic signed [31:0] mem_ff [2 * MAX_GROUP];
   logic signed [31:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/srev_front.sv
// Front end: accepts elements, fills the current bank, closes groups.
`timescale 1ns / 1ps
module srev_front import srev_pkg::*; #(
   parameter int MAX_GROUP = MAX_GROUP_DEFAULT,
   localparam int AW = $clog2(2 * MAX_GROUP),
   localparam int CW = $clog2(MAX_GROUP + 1),
   localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [GS_W-1:0]    group_size,
   input  logic               req_push,
   output logic               req_full,
   input  logic signed [31:0] req_value,
   input  logic               req_end_of_list,
   output logic               mem_wr_en,
   output logic [AW-1:0]      mem_wr_addr,
   output logic signed [31:0] mem_wr_data,
   output logic               desc_push,
   output desc_type           desc_data,
   input  logic               desc_full,
   input  rel_type            release_bank
);

   localparam int KW = (CW > GS_W) ? CW : GS_W;

   logic [CW-1:0] fill_ff, fill_in;
   logic          bank_ff, bank_in;
   logic [1:0]    busy_ff, busy_in;
   logic [CW-1:0] fill_next;
   logic [KW-1:0] k_eff;
   logic          accept;
   logic          close;
   logic [1:0]    busy_set, busy_clr;

   // Effective group size: zero acts as one, large values saturate
   always_comb begin
      if (group_size == '0) begin
         k_eff = KW'(1);
      end else if (KW'(group_size) > KW'(MAX_GROUP)) begin
         k_eff = KW'(MAX_GROUP);
      end else begin
         k_eff = KW'(group_size);
      end
   end

   assign req_full  = busy_ff[bank_ff] | desc_full;
   assign accept    = req_push & ~req_full;
   assign fill_next = fill_ff + CW'(1);
   assign close     = (KW'(fill_next) >= k_eff) | req_end_of_list;

   // Buffer write, bank offset by MAX_GROUP
   assign mem_wr_en   = accept;
   assign mem_wr_addr = bank_ff ? AW'(MAX_GROUP) + AW'(fill_ff[IW-1:0])
                                : AW'(fill_ff[IW-1:0]);
   assign mem_wr_data = req_value;

   // Group descriptor toward the back end
   assign desc_push       = accept & close;
   assign desc_data.bank  = bank_ff;
   assign desc_data.count = DESC_CNT_W'(fill_next);
   assign desc_data.last  = req_end_of_list;

   // Fill count, bank select and bank ownership
   always_comb begin
      fill_in  = fill_ff;
      bank_in  = bank_ff;
      busy_set = 2'b00;
      busy_clr = 2'b00;
      if (accept) begin
         if (close) begin
            fill_in           = '0;
            bank_in           = ~bank_ff;
            busy_set[bank_ff] = 1'b1;
         end else begin
            fill_in = fill_next;
         end
      end
      if (release_bank.valid) begin
         busy_clr[release_bank.bank] = 1'b1;
      end
      busy_in = (busy_ff | busy_set) & ~busy_clr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         bank_ff <= 1'b0;
         busy_ff <= 2'b00;
      end else begin
         fill_ff <= fill_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// File: rtl/core/srev_desc_queue.sv
// Two-entry queue of group descriptors between front and back.
`timescale 1ns / 1ps
module srev_desc_queue import srev_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_data,
   output logic     full,
   input  logic     pop,
   output desc_type pop_data,
   output logic     empty
);

   desc_type   ent_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = ent_ff[rptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   // Pointer and occupancy update
   always_comb begin
      wptr_in = wptr_ff ^ do_push;
      rptr_in = rptr_ff ^ do_pop;
      cnt_in  = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/srev_back.sv
// Back end: reads a closed group newest first and queues the results.
`timescale 1ns / 1ps
module srev_back import srev_pkg::*; #(
   parameter int MAX_GROUP = MAX_GROUP_DEFAULT,
   localparam int AW = $clog2(2 * MAX_GROUP),
   localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               desc_empty,
   input  desc_type           desc_data,
   output logic               desc_pop,
   output logic               mem_rd_en,
   output logic [AW-1:0]      mem_rd_addr,
   input  logic signed [31:0] mem_rd_data,
   output rel_type            release_bank,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output rsp_type            rsp_data
);

   back_state_type state_ff, state_in;
   logic           bank_ff, bank_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic           last_ff, last_in;
   logic           rd_valid_ff, rd_valid_in;
   logic           rd_done_ff, rd_done_in;
   logic           rd_run_ff, rd_run_in;
   rsp_type        ent_ff [2];
   logic           wptr_ff, rptr_ff;
   logic [1:0]     cnt_ff, cnt_in;
   logic [2:0]     occ;
   logic           pop_fire;
   logic           issue;
   logic           final_rd;
   logic [DESC_CNT_W-1:0] cnt_m1;

   assign pop_fire = rsp_pop & (cnt_ff != 2'd0);
   assign final_rd = (idx_ff == '0);
   assign cnt_m1   = desc_data.count - DESC_CNT_W'(1);

   // Result queue occupancy once the data in flight lands
   assign occ = {1'b0, cnt_ff} + {2'b00, rd_valid_ff} - {2'b00, pop_fire};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!desc_empty) begin
               state_in = BACK_RUN;
            end
         end
         BACK_RUN: begin
            if ((occ < 3'd2) && final_rd) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      desc_pop = 1'b0;
      issue    = 1'b0;
      case (state_ff)
         BACK_IDLE: desc_pop = ~desc_empty;
         BACK_RUN:  issue    = (occ < 3'd2);
         default: begin
            desc_pop = 1'b0;
            issue    = 1'b0;
         end
      endcase
   end

   assign mem_rd_en          = issue;
   assign mem_rd_addr        = bank_ff ? AW'(MAX_GROUP) + AW'(idx_ff) : AW'(idx_ff);
   assign release_bank.valid = issue & final_rd;
   assign release_bank.bank  = bank_ff;

   // Group walk: load on descriptor, count down per read
   always_comb begin
      bank_in     = bank_ff;
      idx_in      = idx_ff;
      last_in     = last_ff;
      rd_valid_in = issue;
      rd_done_in  = rd_done_ff;
      rd_run_in   = rd_run_ff;
      if (desc_pop) begin
         bank_in = desc_data.bank;
         idx_in  = cnt_m1[IW-1:0];
         last_in = desc_data.last;
      end else if (issue && !final_rd) begin
         idx_in = idx_ff - IW'(1);
      end
      if (issue) begin
         rd_run_in  = final_rd;
         rd_done_in = final_rd & last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BACK_IDLE;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff    <= bank_in;
      idx_ff     <= idx_in;
      last_ff    <= last_in;
      rd_done_ff <= rd_done_in;
      rd_run_ff  <= rd_run_in;
   end

   // Result queue, two entries
   assign cnt_in    = cnt_ff + {1'b0, rd_valid_ff} - {1'b0, pop_fire};
   assign rsp_empty = (cnt_ff == 2'd0);
   assign rsp_data  = ent_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         wptr_ff <= wptr_ff ^ rd_valid_ff;
         rptr_ff <= rptr_ff ^ pop_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         ent_ff[wptr_ff].out_value <= mem_rd_data;
         ent_ff[wptr_ff].list_done <= rd_done_ff;
         ent_ff[wptr_ff].run_last  <= rd_run_ff;
      end
   end

endmodule

// File: rtl/core/stream_group_reverser_core.sv
// Usage notes:
// Reverses a list in consecutive groups of group_size elements.
// Input queue port: drive req_value / req_end_of_list with req_push; a
// transfer happens on a clock edge with req_push high and req_full low.
// Result queue port: while rsp_empty is low the oldest result sits on
// rsp_out_value / rsp_list_done / rsp_run_last; rsp_pop takes it.
// rsp_run_last marks the last result of a group, rsp_list_done the last
// result of the list. group_size is written over the csr_ APB port
// (byte address 0) while the block is idle; 0 acts as 1, values above
// MAX_GROUP act as MAX_GROUP.
// A transfer that closes a group pushes its descriptor to the back end, which
// pops it and reads the group newest first through the single buffer read
// port. Input takes one element per cycle while req_full is low, into one of
// two buffer banks; the back end reads one element per cycle while the result
// queue has room, after fetching the descriptor of each group.
// Reset (synchronous) empties both queues, frees both banks and sets
// group_size to 1. When the receiver stalls, results back up into the
// two-entry result queue, then the banks; req_full rises once both banks
// hold closed groups.
`timescale 1ns / 1ps
module stream_group_reverser_core import srev_pkg::*; #(
   parameter int MAX_GROUP = MAX_GROUP_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic signed [31:0] req_value,
   input  logic               req_end_of_list,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_out_value,
   output logic               rsp_list_done,
   output logic               rsp_run_last,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int AW = $clog2(2 * MAX_GROUP);

   logic [GS_W-1:0]    gs_ff, gs_in;
   logic               reg_sel;
   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   logic signed [31:0] mem_wr_data;
   logic               mem_rd_en;
   logic [AW-1:0]      mem_rd_addr;
   logic signed [31:0] mem_rd_data;
   logic               desc_push, desc_full, desc_pop, desc_empty;
   desc_type           desc_in_data, desc_out_data;
   rel_type            release_bank;
   rsp_type            rsp_data;

   // Configuration register
   assign csr_pready = 1'b1;
   assign reg_sel    = (csr_paddr[2] == REG_GROUP_SIZE);
   assign csr_prdata = reg_sel ? {{(32 - GS_W){1'b0}}, gs_ff} : 32'd0;

   always_comb begin
      gs_in = gs_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && reg_sel) begin
         gs_in = csr_pwdata[GS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gs_ff <= GS_RESET;
      end else begin
         gs_ff <= gs_in;
      end
   end

   srev_front #(.MAX_GROUP(MAX_GROUP)) u_front (
      .clock           (clock),
      .reset           (reset),
      .group_size      (gs_ff),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_value       (req_value),
      .req_end_of_list (req_end_of_list),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .desc_push       (desc_push),
      .desc_data       (desc_in_data),
      .desc_full       (desc_full),
      .release_bank    (release_bank)
   );

   srev_bank_mem #(.MAX_GROUP(MAX_GROUP)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   srev_desc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_data (desc_in_data),
      .full      (desc_full),
      .pop       (desc_pop),
      .pop_data  (desc_out_data),
      .empty     (desc_empty)
   );

   srev_back #(.MAX_GROUP(MAX_GROUP)) u_back (
      .clock        (clock),
      .reset        (reset),
      .desc_empty   (desc_empty),
      .desc_data    (desc_out_data),
      .desc_pop     (desc_pop),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data),
      .release_bank (release_bank),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data)
   );

   assign rsp_out_value = rsp_data.out_value;
   assign rsp_list_done = rsp_data.list_done;
   assign rsp_run_last  = rsp_data.run_last;

endmodule

// File: rtl/core/srev_checker.sv
// Port-level checks for the stream group reverser, bound to the top level.
`timescale 1ns / 1ps
module srev_port_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_push,
   input logic               req_full,
   input logic signed [31:0] req_value,
   input logic               req_end_of_list,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic signed [31:0] rsp_out_value,
   input logic               rsp_list_done,
   input logic               rsp_run_last,
   input logic               csr_psel,
   input logic               csr_penable,
   input logic               csr_pwrite,
   input logic [2:0]         csr_paddr,
   input logic [31:0]        csr_pwdata,
   input logic [31:0]        csr_prdata,
   input logic               csr_pready
);

   // Reset leaves no result waiting
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // End of list is only flagged on the last result of a run
   a_done_on_run_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_list_done) |-> rsp_run_last)
      else $error("list_done without run_last");

   // A written group size reads back on the next cycle
   a_gs_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2])
      |=> (csr_paddr[2] || csr_prdata[4:0] == $past(csr_pwdata[4:0])))
      else $error("group_size readback mismatch");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_value)))
      else $error("stalled result changed");

endmodule

bind stream_group_reverser_core srev_port_checker u_srev_port_checker (.*);
